/* rtl/core/spq_pkg.sv */
package spq_pkg;

   // Fixed field widths of the request and response items.
   localparam int VALUE_W = 32;
   localparam int PRIO_W  = 8;
   localparam int COUNT_W = 7;
   localparam int STAT_W  = 2;

   // Default number of cells in the chain.
   localparam int CAPACITY_DEFAULT = 64;

   // Capacity register value after reset.
   localparam logic [COUNT_W-1:0] CAP_RESET = 7'd64;

   // Operation codes carried in the kind field.
   localparam logic KIND_INSERT = 1'b0;
   localparam logic KIND_REMOVE = 1'b1;

   // Status codes returned with every response item.
   localparam logic [STAT_W-1:0] STATUS_DONE  = 2'd0;
   localparam logic [STAT_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STAT_W-1:0] STATUS_EMPTY = 2'd2;

   typedef struct packed {
      logic                       kind;
      logic signed [VALUE_W-1:0]  item_value;
      logic [PRIO_W-1:0]          item_priority;
   } req_item_type;

   typedef struct packed {
      logic [STAT_W-1:0]          status;
      logic signed [VALUE_W-1:0]  removed_value;
      logic [PRIO_W-1:0]          removed_priority;
      logic [COUNT_W-1:0]         occupancy;
   } rsp_item_type;

   // One stored entry, as handed between neighboring cells.
   typedef struct packed {
      logic signed [VALUE_W-1:0]  value;
      logic [PRIO_W-1:0]          prio;
   } entry_type;

   // Per-cycle command broadcast to every cell.
   typedef struct packed {
      logic insert;
      logic remove;
   } cell_ctrl_type;

endpackage

/* rtl/core/spq_cell.sv */
module spq_cell (
   input  logic                   clock,
   input  spq_pkg::cell_ctrl_type ctrl,
   input  spq_pkg::entry_type     new_entry,
   input  logic                   occupied,
   input  spq_pkg::entry_type     left_entry,
   input  logic                   left_flag,
   input  spq_pkg::entry_type     right_entry,
   output spq_pkg::entry_type     entry,
   output logic                   flag
);
   import spq_pkg::*;

   entry_type entry_ff;
   entry_type entry_in;

   // A cell is displaced by the new item when it is empty or holds a lower priority.
   // Because the chain is sorted, the flags form a run of zeros followed by ones.
   assign flag  = !occupied || (new_entry.prio > entry_ff.prio);
   assign entry = entry_ff;

   // Insert shifts the displaced run back by one; remove shifts everything forward.
   always_comb begin
      entry_in = entry_ff;
      if (ctrl.insert) begin
         if (left_flag) begin
            entry_in = left_entry;
         end else if (flag) begin
            entry_in = new_entry;
         end
      end else if (ctrl.remove) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

/* rtl/core/sorted_priority_queue.sv */
// Sorted priority queue built as a chain of entry cells, highest priority in cell 0.
// Request channel (req_valid, req_stall, req_item): kind selects insert or remove.
// An insert lands behind every entry of greater or equal priority, so equal
// priorities leave in arrival order. A remove returns the entry in cell 0.
// Response channel (rsp_valid, rsp_stall, rsp_item): exactly one item per request,
// with a status (done, full, empty), the removed entry or zeros, and the occupancy.
// Configuration (csr_valid, csr_ready, csr_data) sets the capacity in use; values
// above CAPACITY act as CAPACITY and zero refuses every insert. csr_ready is always high.
// The response is registered on the edge that accepts the request. Throughput is one
// item per cycle unless the receiver stalls; every cell moves its entry to a neighbor
// in the same cycle, so an item never takes more than the single compare-and-shift step.
// When the receiver stalls, the response register holds its item and req_stall is
// raised, so no new request is taken until the response leaves.
// Reset empties the queue, restores the capacity to 64 and drops any pending response.
// The cell contents are not cleared; the entry count alone tells which cells hold data.
module sorted_priority_queue #(
   parameter int CAPACITY = spq_pkg::CAPACITY_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  spq_pkg::req_item_type       req_item,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output spq_pkg::rsp_item_type       rsp_item,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [spq_pkg::COUNT_W-1:0] csr_data
);
   import spq_pkg::*;

   logic [COUNT_W-1:0] count_ff;
   logic [COUNT_W-1:0] count_in;
   logic [COUNT_W-1:0] cap_ff;
   logic [COUNT_W-1:0] limit;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   rsp_item_type       rsp_item_ff;
   rsp_item_type       rsp_item_in;
   logic               accept;
   logic               is_full;
   logic               is_empty;
   cell_ctrl_type      ctrl;
   entry_type          new_entry;
   entry_type          cell_entry [CAPACITY];
   logic               cell_flag  [CAPACITY];

   // Capacity register; the port never pushes back.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CAP_RESET;
      end else if (csr_valid) begin
         cap_ff <= csr_data;
      end
   end

   // Effective limit saturates at the number of cells.
   assign limit = (32'(cap_ff) > 32'(CAPACITY)) ? COUNT_W'(CAPACITY) : cap_ff;

   // A new request is taken when the response register is free or emptying.
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign is_full   = count_ff >= limit;
   assign is_empty  = count_ff == '0;

   assign ctrl.insert = accept && (req_item.kind == KIND_INSERT) && !is_full;
   assign ctrl.remove = accept && (req_item.kind == KIND_REMOVE) && !is_empty;

   assign new_entry.value = req_item.item_value;
   assign new_entry.prio  = req_item.item_priority;

   // Chain of cells, each wired to its two neighbors.
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      entry_type left_e;
      entry_type right_e;
      logic      left_f;

      if (i == 0) begin : g_head
         assign left_e = new_entry;
         assign left_f = 1'b0;
      end else begin : g_body
         assign left_e = cell_entry[i-1];
         assign left_f = cell_flag[i-1];
      end

      if (i == CAPACITY - 1) begin : g_tail
         assign right_e = cell_entry[i];
      end else begin : g_inner
         assign right_e = cell_entry[i+1];
      end

      spq_cell u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .new_entry   (new_entry),
         .occupied    (32'(i) < 32'(count_ff)),
         .left_entry  (left_e),
         .left_flag   (left_f),
         .right_entry (right_e),
         .entry       (cell_entry[i]),
         .flag        (cell_flag[i])
      );
   end

   // Entry count follows the successful operations.
   always_comb begin
      count_in = count_ff;
      if (ctrl.insert) begin
         count_in = count_ff + COUNT_W'(1);
      end else if (ctrl.remove) begin
         count_in = count_ff - COUNT_W'(1);
      end
   end

   // Response item for the request taken this cycle.
   always_comb begin
      rsp_item_in                  = rsp_item_ff;
      rsp_item_in.status           = STATUS_DONE;
      rsp_item_in.removed_value    = '0;
      rsp_item_in.removed_priority = '0;
      rsp_item_in.occupancy        = count_in;
      if (req_item.kind == KIND_INSERT) begin
         if (is_full) begin
            rsp_item_in.status = STATUS_FULL;
         end
      end else if (is_empty) begin
         rsp_item_in.status = STATUS_EMPTY;
      end else begin
         rsp_item_in.removed_value    = cell_entry[0].value;
         rsp_item_in.removed_priority = cell_entry[0].prio;
      end
   end

   // Response register valid: set on accept, cleared once taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   // The count never runs past the chain length.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= 32'(CAPACITY))
      else $error("entry count exceeds the number of cells");

   // A successful insert grows the count by exactly one.
   a_insert_count: assert property (@(posedge clock) disable iff (reset)
      ctrl.insert |=> count_ff == $past(count_ff) + COUNT_W'(1))
      else $error("insert did not grow the count by one");

   // A successful remove shrinks the count by exactly one.
   a_remove_count: assert property (@(posedge clock) disable iff (reset)
      ctrl.remove |=> count_ff == $past(count_ff) - COUNT_W'(1))
      else $error("remove did not shrink the count by one");

   // Every accepted request shows up as a response with the new occupancy.
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff && (rsp_item_ff.occupancy == count_ff))
      else $error("response missing or occupancy mismatch after accept");

   // Insert and remove never fire together.
   a_ctrl_excl: assert property (@(posedge clock) disable iff (reset)
      !(ctrl.insert && ctrl.remove))
      else $error("insert and remove asserted together");

endmodule
